// ----- sv/cnmt_pkg.sv -----
// Shared types, codes and helpers of the NMT master node monitor.
package cnmt_pkg;

  // Sizing
  localparam int NODE_COUNT_DEF = 128;
  localparam int OPQ_DEPTH      = 2;
  localparam int CFG_W          = 16;

  // Error-control identifier window and frame constants
  localparam logic [10:0] NG_ID_BASE     = 11'h700;
  localparam logic [10:0] NG_ID_LAST     = 11'h77F;
  localparam logic [10:0] NMT_TX_ID      = 11'h000;
  localparam logic [1:0]  NMT_FRAME_LEN  = 2'd2;
  localparam logic [15:0] LOST_TIMEOUT_RST = 16'd3000;

  // Raw heartbeat state values
  localparam logic [6:0] RAW_BOOTUP  = 7'd0;
  localparam logic [6:0] RAW_STOPPED = 7'd4;
  localparam logic [6:0] RAW_OPER    = 7'd5;
  localparam logic [6:0] RAW_PREOP   = 7'h7F;

  // NMT command codes
  localparam logic [7:0] NMT_START      = 8'd1;
  localparam logic [7:0] NMT_STOP       = 8'd2;
  localparam logic [7:0] NMT_PREOP      = 8'd128;
  localparam logic [7:0] NMT_RESET      = 8'd129;
  localparam logic [7:0] NMT_RESET_COMM = 8'd130;

  typedef enum logic [2:0] {
    MODE_FRAME_RX    = 3'd0,
    MODE_SERVICE     = 3'd1,
    MODE_GUARD_START = 3'd2,
    MODE_HB_START    = 3'd3,
    MODE_MON_STOP    = 3'd4,
    MODE_NMT         = 3'd5,
    MODE_QUERY       = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    KIND_REPLY  = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_TX     = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ARG_ERR   = 3'd1,
    ST_LINK_DOWN = 3'd2,
    ST_NOT_PROC  = 3'd3,
    ST_STALE     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    NS_UNDEF   = 3'd0,
    NS_BOOTUP  = 3'd1,
    NS_STOPPED = 3'd2,
    NS_OPER    = 3'd3,
    NS_PREOP   = 3'd4
  } nstate_t;

  typedef enum logic [1:0] {
    CFG_LINK_UP      = 2'd0,
    CFG_REPORT_EN    = 2'd1,
    CFG_LOST_TIMEOUT = 2'd2
  } cfg_idx_t;

  // Work classes handed from the front end to the back end
  typedef enum logic [2:0] {
    OP_REPLY,
    OP_FRAME,
    OP_SERVICE,
    OP_GUARD,
    OP_HBEAT,
    OP_STOP,
    OP_NMT,
    OP_QUERY
  } op_code_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic        link_up;
    logic        report_en;
    logic [15:0] lost_timeout;
  } cfg_t;

  typedef struct packed {
    op_code_t    code;
    status_t     status;
    logic [6:0]  node;
    logic [31:0] time_ms;
    logic [6:0]  raw;
    nstate_t     nstate;
    logic [7:0]  cmd;
    logic [31:0] max_age;
  } op_t;

  typedef struct packed {
    nstate_t     nstate;
    logic [31:0] last_seen;
    logic        guard;
    logic        mon;
  } entry_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [6:0]  node;
    nstate_t     nmt_state;
    logic [6:0]  raw_state;
    logic [10:0] tx_id;
    logic        tx_rtr;
    logic [1:0]  tx_len;
    logic [7:0]  tx_byte0;
    logic [7:0]  tx_byte1;
    logic        last;
  } res_t;

  function automatic nstate_t decode_raw(input logic [6:0] raw);
    nstate_t s;
    case (raw)
      RAW_BOOTUP:  s = NS_BOOTUP;
      RAW_STOPPED: s = NS_STOPPED;
      RAW_OPER:    s = NS_OPER;
      RAW_PREOP:   s = NS_PREOP;
      default:     s = NS_UNDEF;
    endcase
    return s;
  endfunction

  // Result with every field that does not apply cleared
  function automatic res_t mk_res(input kind_t k, input status_t st, input logic [6:0] n);
    res_t r;
    r        = '0;
    r.kind   = k;
    r.status = st;
    r.node   = n;
    return r;
  endfunction

endpackage

// ----- sv/cnmt_in_if.sv -----
// Input item channel: valid/ready with the item fields.
interface cnmt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] time_ms;
  logic [10:0] can_id;
  logic [7:0]  data_byte;
  logic        rtr_flag;
  logic [6:0]  node_id;
  logic [7:0]  command;
  logic [31:0] max_age_ms;

  modport source (
    output valid, mode, time_ms, can_id, data_byte, rtr_flag, node_id, command, max_age_ms,
    input  ready
  );
  modport sink (
    input  valid, mode, time_ms, can_id, data_byte, rtr_flag, node_id, command, max_age_ms,
    output ready
  );
endinterface

// ----- sv/cnmt_out_if.sv -----
// Result channel: valid/ready with the result fields.
interface cnmt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  status;
  logic [6:0]  node_out;
  logic [2:0]  nmt_state;
  logic [6:0]  raw_state;
  logic [10:0] tx_id;
  logic        tx_rtr;
  logic [1:0]  tx_len;
  logic [7:0]  tx_byte0;
  logic [7:0]  tx_byte1;
  logic        last;

  modport source (
    output valid, kind, status, node_out, nmt_state, raw_state, tx_id, tx_rtr, tx_len,
           tx_byte0, tx_byte1, last,
    input  ready
  );
  modport sink (
    input  valid, kind, status, node_out, nmt_state, raw_state, tx_id, tx_rtr, tx_len,
           tx_byte0, tx_byte1, last,
    output ready
  );
endinterface

// ----- sv/cnmt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cnmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- sv/cnmt_front.sv -----
// Front end: takes input items, range-checks them and classifies them into ops.
module cnmt_front
  import cnmt_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  cnmt_in_if.sink in_ch,
  input  cfg_t    cfg,
  input  logic    q_full,
  output logic    push,
  output op_t     push_op
);
  localparam logic [7:0] NC8 = 8'(NODE_COUNT);

  logic [6:0] fn;
  logic       node_in_tbl;
  logic       fn_in_tbl;
  logic       ctl_ok;
  logic       frame_ok;
  logic       cmd_ok;

  // Transfer whenever the op queue has room
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  assign fn          = in_ch.can_id[6:0];
  assign node_in_tbl = {1'b0, in_ch.node_id} < NC8;
  assign fn_in_tbl   = {1'b0, fn} < NC8;
  assign ctl_ok      = (in_ch.node_id != 7'd0) && node_in_tbl;
  assign frame_ok    = (in_ch.can_id > NG_ID_BASE) && (in_ch.can_id <= NG_ID_LAST) &&
                       !in_ch.rtr_flag && fn_in_tbl;
  assign cmd_ok      = (in_ch.command == NMT_START) || (in_ch.command == NMT_STOP) ||
                       (in_ch.command == NMT_PREOP) || (in_ch.command == NMT_RESET) ||
                       (in_ch.command == NMT_RESET_COMM);

  // Classification; anything settled here becomes a plain status reply
  always_comb begin
    push_op         = '0;
    push_op.code    = OP_REPLY;
    push_op.status  = ST_OK;
    push_op.node    = in_ch.node_id;
    push_op.time_ms = in_ch.time_ms;
    push_op.raw     = in_ch.data_byte[6:0];
    push_op.nstate  = decode_raw(in_ch.data_byte[6:0]);
    push_op.cmd     = in_ch.command;
    push_op.max_age = in_ch.max_age_ms;
    case (in_ch.mode)
      MODE_FRAME_RX: begin
        push_op.node = fn;
        if (frame_ok) begin
          push_op.code = OP_FRAME;
        end else begin
          push_op.status = ST_NOT_PROC;
        end
      end
      MODE_SERVICE: begin
        if (!cfg.link_up) begin
          push_op.status = ST_LINK_DOWN;
        end else if (!node_in_tbl) begin
          push_op.status = ST_ARG_ERR;
        end else begin
          push_op.code = OP_SERVICE;
        end
      end
      MODE_GUARD_START: begin
        if (!cfg.link_up) begin
          push_op.status = ST_LINK_DOWN;
        end else if (!ctl_ok) begin
          push_op.status = ST_ARG_ERR;
        end else begin
          push_op.code = OP_GUARD;
        end
      end
      MODE_HB_START: begin
        if (!ctl_ok) begin
          push_op.status = ST_ARG_ERR;
        end else begin
          push_op.code = OP_HBEAT;
        end
      end
      MODE_MON_STOP: begin
        if (!ctl_ok) begin
          push_op.status = ST_ARG_ERR;
        end else begin
          push_op.code = OP_STOP;
        end
      end
      MODE_NMT: begin
        if (!cmd_ok) begin
          push_op.status = ST_ARG_ERR;
        end else if (!cfg.link_up) begin
          push_op.status = ST_LINK_DOWN;
        end else begin
          push_op.code = OP_NMT;
        end
      end
      MODE_QUERY: begin
        if (!ctl_ok) begin
          push_op.status = ST_ARG_ERR;
        end else begin
          push_op.code = OP_QUERY;
        end
      end
      default: begin
        push_op.status = ST_NOT_PROC;
      end
    endcase
  end
endmodule

// ----- sv/cnmt_opq.sv -----
// Short FIFO of classified ops between the front and back ends.
module cnmt_opq
  import cnmt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);
  localparam int PW = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
  localparam int CW = $clog2(OPQ_DEPTH + 1);

  op_t           slot_r [OPQ_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = cnt_r == CW'(OPQ_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_op    = slot_r[rp_r];

  // Pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(OPQ_DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(OPQ_DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_op;
    end
  end
endmodule

// ----- sv/cnmt_back.sv -----
// Back end: node table read-modify-write and result buffer.
module cnmt_back
  import cnmt_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic q_valid,
  input  op_t  q_op,
  output logic q_pop,
  cnmt_out_if.source out_ch
);
  localparam int AW = $clog2(NODE_COUNT);
  localparam int EW = $bits(entry_t);

  bk_state_t       state_r, state_nxt;
  op_t             op_r;
  logic [NODE_COUNT-1:0] vld_r;
  logic            vld_q_r;
  logic [EW-1:0]   rd_data;
  logic            ram_re;
  logic            ram_we;
  entry_t          ent;
  entry_t          wr_ent;
  logic            wr_en;
  res_t            res0_r, res1_r, res0_nxt, res1_nxt, cur;
  logic            res_sel_r;
  logic [1:0]      res_n;
  logic [31:0]     age;
  logic            svc_tx;
  logic            svc_lost;
  logic            start;
  logic            done;

  // Node table: one entry per node, valid bits stand in for the reset values
  cnmt_ram #(
    .WIDTH (EW),
    .DEPTH (NODE_COUNT)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (op_r.node[AW-1:0]),
    .wdata (wr_ent),
    .re    (ram_re),
    .raddr (q_op.node[AW-1:0]),
    .rdata (rd_data)
  );

  assign ent      = vld_q_r ? entry_t'(rd_data) : '0;
  assign age      = op_r.time_ms - ent.last_seen;
  assign svc_tx   = ent.mon && ent.guard;
  assign svc_lost = ent.mon && (age > {16'd0, cfg.lost_timeout});
  assign cur      = res_sel_r ? res1_r : res0_r;

  // Evaluate the op against the entry read
  always_comb begin
    res0_nxt = mk_res(KIND_REPLY, op_r.status, op_r.node);
    res1_nxt = mk_res(KIND_REPLY, ST_OK, op_r.node);
    res_n    = 2'd1;
    wr_en    = 1'b0;
    wr_ent   = ent;
    case (op_r.code)
      OP_REPLY: begin
      end
      OP_FRAME: begin
        wr_en               = 1'b1;
        wr_ent.nstate       = op_r.nstate;
        wr_ent.last_seen    = op_r.time_ms;
        res1_nxt.nmt_state  = op_r.nstate;
        res1_nxt.raw_state  = op_r.raw;
        if (cfg.report_en) begin
          res0_nxt            = mk_res(KIND_REPORT, ST_OK, op_r.node);
          res0_nxt.nmt_state  = op_r.nstate;
          res0_nxt.raw_state  = op_r.raw;
          res_n               = 2'd2;
        end else begin
          res0_nxt = res1_nxt;
        end
      end
      OP_SERVICE: begin
        res0_nxt        = mk_res(KIND_TX, ST_OK, op_r.node);
        res0_nxt.tx_id  = NG_ID_BASE + {4'd0, op_r.node};
        res0_nxt.tx_rtr = 1'b1;
        res0_nxt.tx_len = NMT_FRAME_LEN;
        res1_nxt        = mk_res(KIND_REPORT, ST_OK, op_r.node);
        res_n           = 2'd0;
        if (svc_lost) begin
          wr_en         = 1'b1;
          wr_ent.nstate = NS_UNDEF;
        end
        if (svc_tx) begin
          res_n = (svc_lost && cfg.report_en) ? 2'd2 : 2'd1;
        end else if (svc_lost && cfg.report_en) begin
          res0_nxt = res1_nxt;
          res_n    = 2'd1;
        end
      end
      OP_GUARD: begin
        wr_en            = 1'b1;
        wr_ent.last_seen = op_r.time_ms;
        wr_ent.guard     = 1'b1;
        wr_ent.mon       = 1'b1;
        res0_nxt         = mk_res(KIND_REPLY, ST_OK, op_r.node);
      end
      OP_HBEAT: begin
        wr_en            = 1'b1;
        wr_ent.last_seen = op_r.time_ms;
        wr_ent.guard     = 1'b0;
        wr_ent.mon       = 1'b1;
        res0_nxt         = mk_res(KIND_REPLY, ST_OK, op_r.node);
      end
      OP_STOP: begin
        wr_en        = 1'b1;
        wr_ent.guard = 1'b0;
        wr_ent.mon   = 1'b0;
        res0_nxt     = mk_res(KIND_REPLY, ST_OK, op_r.node);
      end
      OP_NMT: begin
        res0_nxt          = mk_res(KIND_TX, ST_OK, op_r.node);
        res0_nxt.tx_id    = NMT_TX_ID;
        res0_nxt.tx_len   = NMT_FRAME_LEN;
        res0_nxt.tx_byte0 = op_r.cmd;
        res0_nxt.tx_byte1 = {1'b0, op_r.node};
        res_n             = 2'd2;
      end
      OP_QUERY: begin
        if (age < op_r.max_age) begin
          res0_nxt            = mk_res(KIND_REPLY, ST_OK, op_r.node);
          res0_nxt.nmt_state  = ent.nstate;
        end else begin
          res0_nxt = mk_res(KIND_REPLY, ST_STALE, op_r.node);
        end
      end
      default: begin
      end
    endcase
    // mark the final result of the item
    if (res_n == 2'd1) begin
      res0_nxt.last = 1'b1;
    end
    if (res_n == 2'd2) begin
      res1_nxt.last = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        state_nxt = (res_n != 2'd0) ? BK_OUT : BK_IDLE;
      end
      BK_OUT: begin
        if (done) begin
          state_nxt = q_valid ? BK_EXEC : BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // State outputs; the next item's table read overlaps the last transfer
  always_comb begin
    done         = (state_r == BK_OUT) && out_ch.ready && cur.last;
    start        = q_valid && ((state_r == BK_IDLE) || done);
    q_pop        = start;
    ram_re       = start;
    ram_we       = (state_r == BK_EXEC) && wr_en;
    out_ch.valid = state_r == BK_OUT;
  end

  assign out_ch.kind       = cur.kind;
  assign out_ch.status     = cur.status;
  assign out_ch.node_out   = cur.node;
  assign out_ch.nmt_state  = cur.nmt_state;
  assign out_ch.raw_state  = cur.raw_state;
  assign out_ch.tx_id      = cur.tx_id;
  assign out_ch.tx_rtr     = cur.tx_rtr;
  assign out_ch.tx_len     = cur.tx_len;
  assign out_ch.tx_byte0   = cur.tx_byte0;
  assign out_ch.tx_byte1   = cur.tx_byte1;
  assign out_ch.last       = cur.last;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      vld_r     <= '0;
      res_sel_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        vld_r[op_r.node[AW-1:0]] <= 1'b1;
      end
      if ((state_r == BK_EXEC) || done) begin
        res_sel_r <= 1'b0;
      end else if ((state_r == BK_OUT) && out_ch.ready) begin
        res_sel_r <= 1'b1;
      end
    end
  end

  // Op and result payload
  always_ff @(posedge clk) begin
    if (start) begin
      op_r    <= q_op;
      vld_q_r <= vld_r[q_op.node[AW-1:0]];
    end
    if (state_r == BK_EXEC) begin
      res0_r <= res0_nxt;
      res1_r <= res1_nxt;
    end
  end

  // Checks
  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("op queue popped while empty");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_EXEC |=> state_r != BK_EXEC)
    else $error("evaluation held for more than one cycle");

  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> state_r != BK_OUT)
    else $error("result offered again after the final transfer");

  a_second_follows_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_OUT) && res_sel_r |-> !res0_r.last)
    else $error("second result offered after a final first result");
endmodule

// ----- sv/canopen_nmt_master_node_monitor_core.sv -----
// Top level of the CANopen NMT master node monitor.
//
// Keeps a per-node table (decoded state, last-seen time, guard-poll and
// monitored flags) and turns each input item into one or two results, or none
// for a quiet node service. The front end classifies items and queues them two
// deep; the back end reads the node's table entry, evaluates, writes it back and
// offers the results from a small output buffer. In the back end an item goes
// through the table read, then evaluate and write-back, then the output state
// until its final result is taken; an item with no result skips the output
// state, and the next table read still waits for its write-back. Table entries
// are marked valid on first write, so no clearing pass runs after reset.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce.
module canopen_nmt_master_node_monitor_core
  import cnmt_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  cnmt_in_if.sink          in_ch,
  cnmt_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);
  cfg_t cfg_r, cfg_nxt;
  logic q_full;
  logic q_push;
  op_t  q_in_op;
  logic q_pop;
  logic q_valid;
  op_t  q_head;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LINK_UP:      cfg_nxt.link_up      = cfg_wdata[0];
        CFG_REPORT_EN:    cfg_nxt.report_en    = cfg_wdata[0];
        CFG_LOST_TIMEOUT: cfg_nxt.lost_timeout = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.link_up      <= 1'b0;
      cfg_r.report_en    <= 1'b0;
      cfg_r.lost_timeout <= LOST_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cnmt_front #(
    .NODE_COUNT (NODE_COUNT)
  ) u_front (
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .push    (q_push),
    .push_op (q_in_op)
  );

  cnmt_opq u_opq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_in_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_op    (q_head)
  );

  cnmt_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_op    (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );
endmodule
